// ===== hdl/mpvc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mpvc_pkg: shared types and codes for the motorized pot volume controller
// Holds the motor mode codes, the item action codes, the register indexes and the counter limits.
// ----------------------------------------------------------------------------
package mpvc_pkg;

  // Motor mode, as reported on mode_now
  typedef enum logic [1:0] {
    MODE_INIT     = 2'd0,
    MODE_SETTLED  = 2'd1,
    MODE_MOVING   = 2'd2,
    MODE_COASTING = 2'd3
  } motor_mode_t;

  // Item action codes
  localparam logic ACT_POLL = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_POT_LOWEST      = 3'd0;
  localparam cfg_idx_t CFG_POT_HIGHEST     = 3'd1;
  localparam cfg_idx_t CFG_VOLUME_LOWEST   = 3'd2;
  localparam cfg_idx_t CFG_VOLUME_HIGHEST  = 3'd3;
  localparam cfg_idx_t CFG_MOVE_THRESHOLD  = 3'd4;
  localparam cfg_idx_t CFG_ARRIVE_TOL      = 3'd5;
  localparam cfg_idx_t CFG_SETTLE_RUNS     = 3'd6;

  // Volume and settle counter widths and limits
  localparam int unsigned VOL_W   = 8;
  localparam int unsigned RUNS_W  = 3;
  localparam logic [VOL_W-1:0]  VOL_MAX      = 8'hFF;
  localparam logic [VOL_W-1:0]  VOL_LO_RST   = 8'd0;
  localparam logic [VOL_W-1:0]  VOL_HI_RST   = 8'd255;
  localparam logic [RUNS_W-1:0] STABLE_MAX   = 3'd7;
  localparam logic [RUNS_W-1:0] RUNS_RST     = 3'd5;
  localparam int unsigned       THR_RST      = 4;
  localparam int unsigned       TOL_RST      = 4;

endpackage : mpvc_pkg
`default_nettype wire

// ===== hdl/motorized_pot_volume_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motorized_pot_volume_controller: knob poll and motor drive sequencer
// Maps pot readings to volume steps and target volumes to pot positions
// through one shared restoring divider, then runs the four-mode motor machine.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in_     | input     | in_valid / in_ready     | action, pot_reading, volume
//  out_    | output    | out_valid / out_ready   | new_volume, flags, mode_now
//  cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_wdata
//
//  Each transaction runs from acceptance to a valid result through a multiply
//  step, the shared divider at one quotient bit per cycle, an offset add and
//  a decide step, in that order.
//  in_ready is high only while the sequencer is idle; a held result does not
//  block acceptance, but the decide step waits until the output slot is free.
//  Reset (rst_n low, synchronous) restores defaults and the init motor mode.
//  cfg_ready is always high.
//
module motorized_pot_volume_controller #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // input items
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        in_action,
  input  wire [SAMPLE_BITS-1:0]      in_pot_reading,
  input  wire [mpvc_pkg::VOL_W-1:0]  in_volume,
  // results
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [mpvc_pkg::VOL_W-1:0] out_new_volume,
  output logic                       out_volume_changed,
  output logic                       out_drive_update,
  output logic                       out_drive_cw,
  output logic                       out_drive_ccw,
  output logic                       out_backlight_wake,
  output logic [1:0]                 out_mode_now,
  // configuration writes
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire [mpvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [SAMPLE_BITS-1:0]      cfg_wdata
);

  localparam int unsigned S    = SAMPLE_BITS;
  localparam int unsigned VW   = mpvc_pkg::VOL_W;
  localparam int unsigned PW   = 2 * SAMPLE_BITS;   // product / quotient width
  localparam int unsigned RW   = PW + 2;            // signed map result width
  localparam int unsigned DW   = PW + 3;            // signed target distance
  localparam int unsigned CNTW = $clog2(PW);

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_DIV,
    SEQ_FIX,
    SEQ_DONE
  } seq_t;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  seq_t                    seq_r;
  logic [CNTW-1:0]         cnt_r;

  // configuration
  logic [S-1:0]            plo_r, phi_r, thr_r, tol_r;
  logic [VW-1:0]           vlo_r, vhi_r;
  logic [mpvc_pkg::RUNS_W-1:0] runs_r;

  // captured item
  logic                    act_r;
  logic [S-1:0]            rd_r;
  logic [VW-1:0]           vol_r;

  // divider datapath
  logic [PW-1:0]           quo_r;
  logic [S-1:0]            rem_r;
  logic [S-1:0]            den_r;
  logic                    neg_r;
  logic                    zero_r;
  logic [S-1:0]            olo_r;
  logic signed [RW-1:0]    res_r;

  // motor state
  mpvc_pkg::motor_mode_t   mode_r, mode_nxt;
  logic [S-1:0]            last_pot_r, last_pot_nxt;
  logic [VW-1:0]           last_vol_r, last_vol_nxt;
  logic [mpvc_pkg::RUNS_W-1:0] stable_r, stable_nxt;

  // result slot
  logic                    out_valid_r;
  logic [VW-1:0]           nv_r, nv_nxt;
  logic                    chg_r, chg_nxt;
  logic                    upd_r, upd_nxt;
  logic                    cw_r, cw_nxt;
  logic                    ccw_r, ccw_nxt;
  logic                    wake_r, wake_nxt;
  logic [1:0]              mnow_r;

  // --------------------------------------------------------------------------
  // Map operand select: poll maps pot->volume, step maps volume->pot
  // --------------------------------------------------------------------------
  logic [S-1:0]            x_sel, ilo_sel, ihi_sel, olo_sel, ohi_sel;
  logic signed [S:0]       num_s, spo_s, den_s;
  logic [S-1:0]            num_mag, spo_mag, den_mag;
  logic [PW-1:0]           prod;

  always_comb begin
    if (act_r == mpvc_pkg::ACT_POLL) begin
      x_sel   = rd_r;
      ilo_sel = plo_r;
      ihi_sel = phi_r;
      olo_sel = S'(vlo_r);
      ohi_sel = S'(vhi_r);
    end else begin
      x_sel   = S'(vol_r);
      ilo_sel = S'(vlo_r);
      ihi_sel = S'(vhi_r);
      olo_sel = plo_r;
      ohi_sel = phi_r;
    end
    num_s   = $signed({1'b0, x_sel})   - $signed({1'b0, ilo_sel});
    spo_s   = $signed({1'b0, ohi_sel}) - $signed({1'b0, olo_sel});
    den_s   = $signed({1'b0, ihi_sel}) - $signed({1'b0, ilo_sel});
    num_mag = num_s[S] ? S'(-num_s) : S'(num_s);
    spo_mag = spo_s[S] ? S'(-spo_s) : S'(spo_s);
    den_mag = den_s[S] ? S'(-den_s) : S'(den_s);
    prod    = PW'(num_mag) * PW'(spo_mag);
  end

  // --------------------------------------------------------------------------
  // Shared restoring divider step: one quotient bit per cycle
  // --------------------------------------------------------------------------
  logic [S:0]              trial, trial_sub;
  logic                    trial_ge;

  always_comb begin
    trial     = {rem_r, quo_r[PW-1]};
    trial_sub = trial - {1'b0, den_r};
    trial_ge  = (trial >= {1'b0, den_r});
  end

  // signed offset add after the divide
  logic signed [RW-1:0]    q_s, olo_s, res_nxt;

  always_comb begin
    q_s     = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
    olo_s   = $signed(RW'(olo_r));
    res_nxt = zero_r ? olo_s : olo_s + q_s;
  end

  // --------------------------------------------------------------------------
  // Decide: knob poll result or motor mode step
  // --------------------------------------------------------------------------
  logic [VW-1:0]           sat_vol;
  logic [S-1:0]            pot_dist;
  logic                    pot_far;
  logic signed [DW-1:0]    tgt_diff;
  logic [DW-1:0]           tgt_abs;
  logic                    tgt_near;
  logic [mpvc_pkg::RUNS_W-1:0] stable_inc;

  always_comb begin
    // saturate map to a byte
    if (res_r[RW-1])
      sat_vol = '0;
    else if (|res_r[RW-2:VW])
      sat_vol = mpvc_pkg::VOL_MAX;
    else
      sat_vol = res_r[VW-1:0];

    pot_dist = (rd_r >= last_pot_r) ? rd_r - last_pot_r : last_pot_r - rd_r;
    pot_far  = (pot_dist > thr_r);

    tgt_diff = DW'(res_r) - $signed({{(DW-S){1'b0}}, rd_r});
    tgt_abs  = tgt_diff[DW-1] ? DW'(-tgt_diff) : DW'(tgt_diff);
    tgt_near = (tgt_abs <= DW'(tol_r));

    stable_inc = (stable_r == mpvc_pkg::STABLE_MAX) ? stable_r : stable_r + 1'b1;

    mode_nxt     = mode_r;
    last_pot_nxt = last_pot_r;
    last_vol_nxt = last_vol_r;
    stable_nxt   = stable_r;
    nv_nxt       = vol_r;
    chg_nxt      = 1'b0;
    upd_nxt      = 1'b0;
    cw_nxt       = 1'b0;
    ccw_nxt      = 1'b0;
    wake_nxt     = 1'b0;

    if (act_r == mpvc_pkg::ACT_POLL) begin
      if ((mode_r == mpvc_pkg::MODE_INIT || mode_r == mpvc_pkg::MODE_SETTLED) && pot_far) begin
        nv_nxt = sat_vol;
        if (sat_vol != vol_r) begin
          chg_nxt      = 1'b1;
          wake_nxt     = 1'b1;
          last_pot_nxt = rd_r;
          last_vol_nxt = sat_vol;
        end
      end
    end else begin
      unique case (mode_r)
        mpvc_pkg::MODE_INIT: begin
          mode_nxt     = mpvc_pkg::MODE_SETTLED;
          last_vol_nxt = vol_r;
        end
        mpvc_pkg::MODE_SETTLED: begin
          if (vol_r != last_vol_r) begin
            last_pot_nxt = rd_r;
            mode_nxt     = mpvc_pkg::MODE_MOVING;
          end
          last_vol_nxt = vol_r;
        end
        mpvc_pkg::MODE_MOVING: begin
          wake_nxt   = 1'b1;
          stable_nxt = '0;
          upd_nxt    = 1'b1;
          if (tgt_near)
            mode_nxt = mpvc_pkg::MODE_COASTING;
          else if (!tgt_diff[DW-1] && (tgt_diff != '0))
            cw_nxt = 1'b1;
          else
            ccw_nxt = 1'b1;
        end
        mpvc_pkg::MODE_COASTING: begin
          wake_nxt = 1'b1;
          if (rd_r == last_pot_r) begin
            stable_nxt = stable_inc;
            if (stable_inc >= runs_r)
              mode_nxt = mpvc_pkg::MODE_SETTLED;
          end else begin
            stable_nxt = '0;
          end
          last_pot_nxt = rd_r;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshakes
  // --------------------------------------------------------------------------
  logic in_fire, out_fire, done_fire;

  assign in_ready  = (seq_r == SEQ_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign done_fire = (seq_r == SEQ_DONE) && (!out_valid_r || out_ready);

  // --------------------------------------------------------------------------
  // Sequencer, datapath and state registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SEQ_IDLE;
      cnt_r       <= '0;
      plo_r       <= '0;
      phi_r       <= '1;
      vlo_r       <= mpvc_pkg::VOL_LO_RST;
      vhi_r       <= mpvc_pkg::VOL_HI_RST;
      thr_r       <= S'(mpvc_pkg::THR_RST);
      tol_r       <= S'(mpvc_pkg::TOL_RST);
      runs_r      <= mpvc_pkg::RUNS_RST;
      mode_r      <= mpvc_pkg::MODE_INIT;
      last_pot_r  <= '0;
      last_vol_r  <= '0;
      stable_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid) begin
        unique case (cfg_index)
          mpvc_pkg::CFG_POT_LOWEST:     plo_r  <= cfg_wdata;
          mpvc_pkg::CFG_POT_HIGHEST:    phi_r  <= cfg_wdata;
          mpvc_pkg::CFG_VOLUME_LOWEST:  vlo_r  <= cfg_wdata[VW-1:0];
          mpvc_pkg::CFG_VOLUME_HIGHEST: vhi_r  <= cfg_wdata[VW-1:0];
          mpvc_pkg::CFG_MOVE_THRESHOLD: thr_r  <= cfg_wdata;
          mpvc_pkg::CFG_ARRIVE_TOL:     tol_r  <= cfg_wdata;
          mpvc_pkg::CFG_SETTLE_RUNS:    runs_r <= cfg_wdata[mpvc_pkg::RUNS_W-1:0];
          default: ;
        endcase
      end

      // result slot empties unless a new result is loaded in the same cycle
      if (out_fire && !done_fire)
        out_valid_r <= 1'b0;

      unique case (seq_r)
        SEQ_IDLE: begin
          if (in_fire) begin
            act_r <= in_action;
            rd_r  <= in_pot_reading;
            vol_r <= in_volume;
            seq_r <= SEQ_MUL;
          end
        end
        SEQ_MUL: begin
          quo_r  <= prod;
          rem_r  <= '0;
          den_r  <= den_mag;
          neg_r  <= num_s[S] ^ spo_s[S] ^ den_s[S];
          zero_r <= (den_mag == '0);
          olo_r  <= olo_sel;
          cnt_r  <= CNTW'(PW - 1);
          seq_r  <= SEQ_DIV;
        end
        SEQ_DIV: begin
          rem_r <= trial_ge ? trial_sub[S-1:0] : trial[S-1:0];
          quo_r <= {quo_r[PW-2:0], trial_ge};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0)
            seq_r <= SEQ_FIX;
        end
        SEQ_FIX: begin
          res_r <= res_nxt;
          seq_r <= SEQ_DONE;
        end
        SEQ_DONE: begin
          if (done_fire) begin
            mode_r      <= mode_nxt;
            last_pot_r  <= last_pot_nxt;
            last_vol_r  <= last_vol_nxt;
            stable_r    <= stable_nxt;
            nv_r        <= nv_nxt;
            chg_r       <= chg_nxt;
            upd_r       <= upd_nxt;
            cw_r        <= cw_nxt;
            ccw_r       <= ccw_nxt;
            wake_r      <= wake_nxt;
            mnow_r      <= mode_nxt;
            out_valid_r <= 1'b1;
            seq_r       <= SEQ_IDLE;
          end
        end
        default: seq_r <= SEQ_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Outputs
  // --------------------------------------------------------------------------
  assign out_valid          = out_valid_r;
  assign out_new_volume     = nv_r;
  assign out_volume_changed = chg_r;
  assign out_drive_update   = upd_r;
  assign out_drive_cw       = cw_r;
  assign out_drive_ccw      = ccw_r;
  assign out_backlight_wake = wake_r;
  assign out_mode_now       = mnow_r;

`ifndef NO_ASSERTIONS
  // motor never driven both ways at once
  a_drive_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_drive_cw && out_drive_ccw))
    else $error("cw and ccw both driven");

  // drive levels only accompany a drive update
  a_drive_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_drive_cw || out_drive_ccw) |-> out_drive_update)
    else $error("drive level without drive update");

  // a volume change comes from a poll in init or settled and wakes the display
  a_change_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_volume_changed |->
      out_backlight_wake &&
      (out_mode_now == mpvc_pkg::MODE_INIT || out_mode_now == mpvc_pkg::MODE_SETTLED))
    else $error("volume change outside init/settled");

  // a drive update leaves the motor moving or coasting
  a_update_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_update |->
      (out_mode_now == mpvc_pkg::MODE_MOVING || out_mode_now == mpvc_pkg::MODE_COASTING))
    else $error("drive update in wrong mode");
`endif

endmodule : motorized_pot_volume_controller
`default_nettype wire

// ===== sim/motorized_pot_volume_controller_tb.sv =====
// ----------------------------------------------------------------------------
// motorized_pot_volume_controller_tb: self-checking bench for the pot controller
// Runs knob polls and motor steps through the four motor modes under a series
// of register settings, predicts every result and compares it field by field.
// ----------------------------------------------------------------------------
module motorized_pot_volume_controller_tb;

  localparam int unsigned POT_BITS      = 10;
  localparam int unsigned LATENCY       = 2 * POT_BITS + 3;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned RANDOM_PHASES = 10;
  localparam int unsigned PHASE_ITEMS   = 145;
  localparam int          POT_TOP       = 1023;

  // One result transaction as seen on the out_ channel
  typedef struct packed {
    logic [mpvc_pkg::VOL_W-1:0] new_volume;
    logic                       changed;
    logic                       drive_update;
    logic                       cw;
    logic                       ccw;
    logic                       wake;
    logic [1:0]                 mode;
  } knob_result_t;

  // Scoreboard: tracks controller state and the results still owed
  class volume_scoreboard;
    // register copies
    logic [POT_BITS-1:0]         pot_lo, pot_hi, move_thr, arrive_tol;
    logic [mpvc_pkg::VOL_W-1:0]  vol_lo, vol_hi;
    logic [mpvc_pkg::RUNS_W-1:0] runs_needed;
    // controller state
    mpvc_pkg::motor_mode_t       mode;
    logic [POT_BITS-1:0]         pot_memo;
    logic [mpvc_pkg::VOL_W-1:0]  vol_memo;
    logic [mpvc_pkg::RUNS_W-1:0] steady;
    knob_result_t                waiting[$];
    // bookkeeping
    int unsigned faults, checked, items, changes, drives;
    int unsigned mode_hits[4];

    function new();
      pot_lo      = '0;
      pot_hi      = POT_BITS'(POT_TOP);
      vol_lo      = mpvc_pkg::VOL_LO_RST;
      vol_hi      = mpvc_pkg::VOL_HI_RST;
      move_thr    = POT_BITS'(mpvc_pkg::THR_RST);
      arrive_tol  = POT_BITS'(mpvc_pkg::TOL_RST);
      runs_needed = mpvc_pkg::RUNS_RST;
      mode        = mpvc_pkg::MODE_INIT;
      pot_memo    = '0;
      vol_memo    = '0;
      steady      = '0;
    endfunction

    function void set_reg(mpvc_pkg::cfg_idx_t idx, logic [POT_BITS-1:0] val);
      case (idx)
        mpvc_pkg::CFG_POT_LOWEST:     pot_lo = val;
        mpvc_pkg::CFG_POT_HIGHEST:    pot_hi = val;
        mpvc_pkg::CFG_VOLUME_LOWEST:  vol_lo = val[mpvc_pkg::VOL_W-1:0];
        mpvc_pkg::CFG_VOLUME_HIGHEST: vol_hi = val[mpvc_pkg::VOL_W-1:0];
        mpvc_pkg::CFG_MOVE_THRESHOLD: move_thr = val;
        mpvc_pkg::CFG_ARRIVE_TOL:     arrive_tol = val;
        mpvc_pkg::CFG_SETTLE_RUNS:    runs_needed = val[mpvc_pkg::RUNS_W-1:0];
        default: ;
      endcase
    endfunction

    // linear map, quotient truncated toward zero; flat input span gives out_lo
    function longint scale(longint x, longint in_lo, longint in_hi,
                           longint out_lo, longint out_hi);
      if (in_hi == in_lo) return out_lo;
      return out_lo + ((x - in_lo) * (out_hi - out_lo)) / (in_hi - in_lo);
    endfunction

    function longint gap(longint a, longint b);
      return (a > b) ? a - b : b - a;
    endfunction

    // volume a knob reading maps to, saturated to a byte
    function logic [mpvc_pkg::VOL_W-1:0] knob_volume(logic [POT_BITS-1:0] rd);
      longint m;
      m = scale(rd, pot_lo, pot_hi, vol_lo, vol_hi);
      if (m < 0) m = 0;
      if (m > 255) m = 255;
      return m[mpvc_pkg::VOL_W-1:0];
    endfunction

    function longint motor_target(logic [mpvc_pkg::VOL_W-1:0] vol);
      return scale(vol, vol_lo, vol_hi, pot_lo, pot_hi);
    endfunction

    // accepted input transaction: advance the state, queue the result
    function void note_item(logic act, logic [POT_BITS-1:0] rd,
                            logic [mpvc_pkg::VOL_W-1:0] vol);
      knob_result_t r;
      longint tgt;
      longint rdl;
      rdl = rd;
      r.new_volume   = vol;
      r.changed      = 1'b0;
      r.drive_update = 1'b0;
      r.cw           = 1'b0;
      r.ccw          = 1'b0;
      r.wake         = 1'b0;
      if (act == mpvc_pkg::ACT_POLL) begin
        // knob only counts while the motor is idle
        if ((mode == mpvc_pkg::MODE_SETTLED || mode == mpvc_pkg::MODE_INIT) &&
            gap(rdl, pot_memo) > longint'(move_thr)) begin
          r.new_volume = knob_volume(rd);
          if (r.new_volume != vol) begin
            r.changed = 1'b1;
            r.wake    = 1'b1;
            pot_memo  = rd;
            vol_memo  = r.new_volume;
          end
        end
      end else begin
        tgt = motor_target(vol);
        case (mode)
          mpvc_pkg::MODE_INIT: begin
            mode     = mpvc_pkg::MODE_SETTLED;
            vol_memo = vol;
          end
          mpvc_pkg::MODE_SETTLED: begin
            if (vol != vol_memo) begin
              pot_memo = rd;
              mode     = mpvc_pkg::MODE_MOVING;
            end
            vol_memo = vol;
          end
          mpvc_pkg::MODE_MOVING: begin
            r.wake         = 1'b1;
            r.drive_update = 1'b1;
            steady         = '0;
            if (gap(tgt, rdl) <= longint'(arrive_tol)) mode = mpvc_pkg::MODE_COASTING;
            else if (rdl < tgt) r.cw = 1'b1;
            else r.ccw = 1'b1;
          end
          default: begin
            // coasting: count equal readings until settled
            r.wake = 1'b1;
            if (rd == pot_memo) begin
              if (steady != mpvc_pkg::STABLE_MAX) steady++;
              if (steady >= runs_needed) mode = mpvc_pkg::MODE_SETTLED;
            end else begin
              steady = '0;
            end
            pot_memo = rd;
          end
        endcase
      end
      r.mode = mode;
      waiting.push_back(r);
      items++;
      mode_hits[mode]++;
      changes += r.changed;
      drives  += r.drive_update;
    endfunction

    function int unsigned outstanding();
      return waiting.size();
    endfunction

    task report(string msg);
      faults++;
      if (faults <= 50) $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, int unsigned want, int unsigned seen);
      if (want != seen)
        report($sformatf("result %0d: %s expected %0d, got %0d", checked, name, want, seen));
    endtask

    // accepted result transaction: compare with the oldest expectation
    task check_result(knob_result_t got);
      knob_result_t want;
      if (waiting.size() == 0) begin
        report($sformatf("result with no pending item (volume %0d)", got.new_volume));
        return;
      end
      want = waiting.pop_front();
      compare_field("new_volume", want.new_volume, got.new_volume);
      compare_field("volume_changed", want.changed, got.changed);
      compare_field("drive_update", want.drive_update, got.drive_update);
      compare_field("drive_cw", want.cw, got.cw);
      compare_field("drive_ccw", want.ccw, got.ccw);
      compare_field("backlight_wake", want.wake, got.wake);
      compare_field("mode_now", want.mode, got.mode);
      checked++;
    endtask
  endclass

  // DUT signals
  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_action;
  logic [POT_BITS-1:0]        in_pot_reading;
  logic [mpvc_pkg::VOL_W-1:0] in_volume;
  logic                       out_valid;
  logic                       out_ready;
  logic [mpvc_pkg::VOL_W-1:0] out_new_volume;
  logic                       out_volume_changed;
  logic                       out_drive_update;
  logic                       out_drive_cw;
  logic                       out_drive_ccw;
  logic                       out_backlight_wake;
  logic [1:0]                 out_mode_now;
  logic                       cfg_valid;
  logic                       cfg_ready;
  mpvc_pkg::cfg_idx_t         cfg_index;
  logic [POT_BITS-1:0]        cfg_wdata;

  volume_scoreboard           sb;
  int unsigned                cycles;
  int unsigned                burst_left;
  int unsigned                settings;
  int                         motor_pos;
  logic [mpvc_pkg::VOL_W-1:0] goal_vol;
  // receiver stall pattern
  int unsigned                style, style_left, hold;

  motorized_pot_volume_controller #(
    .SAMPLE_BITS(POT_BITS)
  ) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_action          (in_action),
    .in_pot_reading     (in_pot_reading),
    .in_volume          (in_volume),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_new_volume     (out_new_volume),
    .out_volume_changed (out_volume_changed),
    .out_drive_update   (out_drive_update),
    .out_drive_cw       (out_drive_cw),
    .out_drive_ccw      (out_drive_ccw),
    .out_backlight_wake (out_backlight_wake),
    .out_mode_now       (out_mode_now),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // watchdog
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("TIMEOUT after %0d cycles, %0d results still owed", cycles, sb.outstanding());
    $display("Mismatches found");
    $finish;
  end

  // receiver: switches between always ready, coin flips and long stalls
  always @(negedge clk) begin
    if (style_left == 0) begin
      style      = $urandom_range(0, 2);
      style_left = $urandom_range(50, 300);
    end else begin
      style_left--;
    end
    case (style)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (hold > 0) begin
          hold--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          hold = $urandom_range(1, 30);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(knob_result_t'{out_new_volume, out_volume_changed, out_drive_update,
                                     out_drive_cw, out_drive_ccw, out_backlight_wake,
                                     out_mode_now});
  end

  function automatic int clamp_pot(int v);
    return (v < 0) ? 0 : ((v > POT_TOP) ? POT_TOP : v);
  endfunction

  // send one input transaction; bursts of items separated by random gaps
  task automatic send_item(logic act, logic [POT_BITS-1:0] rd,
                           logic [mpvc_pkg::VOL_W-1:0] vol);
    @(negedge clk);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6))
        @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid       = 1'b1;
    in_action      = act;
    in_pot_reading = rd;
    in_volume      = vol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(act, rd, vol);
    burst_left--;
  endtask

  // stop sending, wait for all results, then let the pipeline drain
  task automatic wait_idle();
    int unsigned n;
    @(negedge clk);
    in_valid = 1'b0;
    for (n = 0; n < IDLE_LIMIT && sb.outstanding() != 0; n++) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic cfg_write(mpvc_pkg::cfg_idx_t idx, logic [POT_BITS-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // write the full register set while idle
  task automatic load_config(logic [POT_BITS-1:0] plo, logic [POT_BITS-1:0] phi,
                             logic [POT_BITS-1:0] vlo, logic [POT_BITS-1:0] vhi,
                             logic [POT_BITS-1:0] thr, logic [POT_BITS-1:0] tol,
                             logic [POT_BITS-1:0] runs);
    wait_idle();
    cfg_write(mpvc_pkg::CFG_POT_LOWEST, plo);
    cfg_write(mpvc_pkg::CFG_POT_HIGHEST, phi);
    cfg_write(mpvc_pkg::CFG_VOLUME_LOWEST, vlo);
    cfg_write(mpvc_pkg::CFG_VOLUME_HIGHEST, vhi);
    cfg_write(mpvc_pkg::CFG_MOVE_THRESHOLD, thr);
    cfg_write(mpvc_pkg::CFG_ARRIVE_TOL, tol);
    cfg_write(mpvc_pkg::CFG_SETTLE_RUNS, runs);
    @(negedge clk);
    cfg_valid = 1'b0;
    settings++;
  endtask

  // random items shaped after the predicted motor mode, with some noise
  task automatic play_random(int unsigned count);
    int unsigned                k;
    logic                       act;
    logic [POT_BITS-1:0]        rd;
    logic [mpvc_pkg::VOL_W-1:0] vol;
    longint                     tgt;
    int                         off, lo_v, hi_v;
    for (k = 0; k < count; k++) begin
      lo_v = (sb.vol_lo < sb.vol_hi) ? int'(sb.vol_lo) : int'(sb.vol_hi);
      hi_v = (sb.vol_lo < sb.vol_hi) ? int'(sb.vol_hi) : int'(sb.vol_lo);
      act  = mpvc_pkg::ACT_STEP;
      rd   = POT_BITS'(motor_pos);
      vol  = goal_vol;
      if ($urandom_range(0, 99) < 12) begin
        // noise: anything goes
        act = 1'($urandom);
        rd  = POT_BITS'($urandom);
        vol = mpvc_pkg::VOL_W'($urandom);
      end else begin
        case (sb.mode)
          mpvc_pkg::MODE_SETTLED: begin
            if ($urandom_range(0, 1) == 0) begin
              // knob turned: random spot or right at the threshold edge
              act = mpvc_pkg::ACT_POLL;
              if ($urandom_range(0, 1) == 0)
                motor_pos = $urandom_range(0, POT_TOP);
              else
                motor_pos = clamp_pot(int'(sb.pot_memo) + ($urandom_range(0, 1) ? 1 : -1) *
                                      (int'(sb.move_thr) + int'($urandom_range(0, 1))));
              rd  = POT_BITS'(motor_pos);
              vol = ($urandom_range(0, 1) == 0) ? sb.knob_volume(rd)
                                                : mpvc_pkg::VOL_W'($urandom);
            end else if ($urandom_range(0, 3) == 0) begin
              vol = sb.vol_memo;
            end else begin
              goal_vol = ($urandom_range(0, 7) == 0)
                         ? mpvc_pkg::VOL_W'($urandom)
                         : mpvc_pkg::VOL_W'($urandom_range(lo_v, hi_v));
              vol = goal_vol;
            end
          end
          mpvc_pkg::MODE_MOVING: begin
            tgt = sb.motor_target(goal_vol);
            if (tgt < 0 || tgt > POT_TOP) begin
              goal_vol = mpvc_pkg::VOL_W'($urandom_range(lo_v, hi_v));
              tgt = sb.motor_target(goal_vol);
            end
            // motor travels toward the target, landing near it with some overshoot
            off = (sb.arrive_tol < 6) ? int'(sb.arrive_tol) : 6;
            if (((tgt > motor_pos) ? tgt - motor_pos : motor_pos - tgt) <= 48 ||
                $urandom_range(0, 3) == 0) begin
              motor_pos = int'(tgt) + int'($urandom_range(0, 2 * off)) - off;
              if ($urandom_range(0, 5) == 0)
                motor_pos += ($urandom_range(0, 1) ? 1 : -1) * (off + int'($urandom_range(1, 5)));
            end else begin
              motor_pos += ((tgt > motor_pos) ? 1 : -1) * int'($urandom_range(8, 48));
            end
            motor_pos = clamp_pot(motor_pos);
            rd  = POT_BITS'(motor_pos);
            vol = goal_vol;
            if ($urandom_range(0, 9) == 0) act = mpvc_pkg::ACT_POLL;
          end
          mpvc_pkg::MODE_COASTING: begin
            // mostly steady readings, an occasional jitter restarts the count
            if ($urandom_range(0, 9) == 0)
              motor_pos = clamp_pot(motor_pos + ($urandom_range(0, 1) ? 1 : -1));
            rd = POT_BITS'(motor_pos);
            if ($urandom_range(0, 9) == 0) act = mpvc_pkg::ACT_POLL;
          end
          default: begin
            rd  = POT_BITS'($urandom);
            vol = mpvc_pkg::VOL_W'($urandom);
          end
        endcase
      end
      send_item(act, rd, vol);
    end
  endtask

  // main sequence
  initial begin
    int unsigned ph;
    logic [POT_BITS-1:0] span;
    sb             = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = mpvc_pkg::ACT_POLL;
    in_pot_reading = '0;
    in_volume      = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = mpvc_pkg::CFG_POT_LOWEST;
    cfg_wdata      = '0;
    cycles         = 0;
    burst_left     = 0;
    settings       = 1;
    motor_pos      = 0;
    goal_vol       = '0;
    style          = 0;
    style_left     = 0;
    hold           = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset register values
    send_item(mpvc_pkg::ACT_POLL, 10'd0, 8'd0);       // init, no movement
    send_item(mpvc_pkg::ACT_POLL, 10'd1023, 8'd0);    // full-scale knob
    send_item(mpvc_pkg::ACT_POLL, 10'd512, 8'd127);   // maps to the same volume
    send_item(mpvc_pkg::ACT_STEP, 10'd0, 8'd255);     // init -> settled
    send_item(mpvc_pkg::ACT_STEP, 10'd0, 8'd255);     // same volume stays settled
    send_item(mpvc_pkg::ACT_STEP, 10'd0, 8'd0);       // new volume -> moving
    send_item(mpvc_pkg::ACT_STEP, 10'd1023, 8'd0);    // above target: ccw
    send_item(mpvc_pkg::ACT_STEP, 10'd0, 8'd255);     // below target: cw
    send_item(mpvc_pkg::ACT_POLL, 10'd300, 8'd40);    // poll ignored while moving
    send_item(mpvc_pkg::ACT_STEP, 10'd1021, 8'd255);  // within tolerance -> coasting
    send_item(mpvc_pkg::ACT_POLL, 10'd1021, 8'd255);  // poll ignored while coasting
    send_item(mpvc_pkg::ACT_STEP, 10'd1020, 8'd255);  // differing reading clears count
    repeat (5) send_item(mpvc_pkg::ACT_STEP, 10'd1020, 8'd255);

    // directed, flat spans, zero threshold and tolerance, zero settle runs
    load_config(10'd500, 10'd500, 10'd77, 10'd77, 10'd0, 10'd0, 10'd0);
    send_item(mpvc_pkg::ACT_POLL, 10'd700, 8'd3);     // flat pot span gives volume_lowest
    send_item(mpvc_pkg::ACT_STEP, 10'd10, 8'd90);     // -> moving
    send_item(mpvc_pkg::ACT_STEP, 10'd10, 8'd90);     // flat volume span targets pot_lowest
    send_item(mpvc_pkg::ACT_STEP, 10'd500, 8'd90);    // exact hit -> coasting
    send_item(mpvc_pkg::ACT_STEP, 10'd500, 8'd90);
    send_item(mpvc_pkg::ACT_STEP, 10'd500, 8'd90);    // first equal reading settles
    motor_pos = 500;

    // random phases over a spread of register settings
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      span = POT_BITS'($urandom_range(0, POT_TOP));
      case (ph)
        0: load_config(10'd0, 10'd1023, 10'd0, 10'd255, 10'd0, 10'd0, 10'd7);
        1: load_config(10'd1023, 10'd0, 10'd255, 10'd0, 10'd1023, 10'd1023, 10'd1);
        2: load_config(10'd300, 10'd700, 10'd20, 10'd200, 10'd8, 10'd16, 10'd3);
        3: load_config(10'd0, 10'd1023, 10'd0, 10'd255, POT_BITS'(mpvc_pkg::THR_RST),
                       POT_BITS'(mpvc_pkg::TOL_RST), POT_BITS'(mpvc_pkg::RUNS_RST));
        4: load_config(span, span, POT_BITS'($urandom_range(0, 255)),
                       POT_BITS'($urandom_range(0, 255)), POT_BITS'($urandom_range(0, 40)),
                       POT_BITS'($urandom_range(0, 40)), POT_BITS'($urandom_range(1, 7)));
        default: load_config(POT_BITS'($urandom_range(0, POT_TOP)),
                             POT_BITS'($urandom_range(0, POT_TOP)),
                             POT_BITS'($urandom_range(0, 255)), POT_BITS'($urandom_range(0, 255)),
                             POT_BITS'($urandom_range(0, 63)), POT_BITS'($urandom_range(0, 63)),
                             POT_BITS'($urandom_range(1, 7)));
      endcase
      play_random(PHASE_ITEMS);
    end

    wait_idle();
    if (sb.outstanding() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.outstanding()));
    $display("Ran %0d items under %0d register settings, %0d results checked.",
             sb.items, settings, sb.checked);
    $display("Modes: init %0d, settled %0d, moving %0d, coasting %0d; %0d changes, %0d drives.",
             sb.mode_hits[0], sb.mode_hits[1], sb.mode_hits[2], sb.mode_hits[3],
             sb.changes, sb.drives);
    if (sb.faults == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== motorized_pot_volume_controller.f =====
hdl/mpvc_pkg.sv
hdl/motorized_pot_volume_controller.sv
sim/motorized_pot_volume_controller_tb.sv
